/* src/mqe_pkg.sv */
// Package: shared types, constants and the Gray phase table for the quadrature emulator.
`timescale 1ns / 1ps

package mqe_pkg;

    localparam int DELTA_W   = 8;
    localparam int BUTTONS_W = 8;
    localparam int PENDING_W = 16;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    // Item kinds
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_PINOUT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BUTTONS = 1'b1;

    // Phase step increments (mod 4)
    localparam logic [PHASE_W-1:0] PHASE_FWD  = 2'b01;
    localparam logic [PHASE_W-1:0] PHASE_BACK = 2'b11;

    // Both buttons released (active low levels)
    localparam logic [1:0] BUTTONS_RELEASED = 2'b11;

    typedef struct packed {
        logic                        opcode;
        logic signed [DELTA_W-1:0]   delta_x;
        logic signed [DELTA_W-1:0]   delta_y;
        logic [BUTTONS_W-1:0]        button_bits;
    } t_in_req;

    typedef struct packed {
        logic pin_x1;
        logic pin_x2;
        logic pin_y1;
        logic pin_y2;
        logic left_button_n;
        logic right_button_n;
    } t_out_req;

    // Phase index to pin pattern, sequence 00, 01, 11, 10 (bit 0 phase A, bit 1 phase B)
    function automatic logic [PHASE_W-1:0] gray_of(input logic [PHASE_W-1:0] idx);
        logic [PHASE_W-1:0] g;
        case (idx)
            2'd0:    g = 2'b00;
            2'd1:    g = 2'b01;
            2'd2:    g = 2'b11;
            2'd3:    g = 2'b10;
            default: g = 2'b00;
        endcase
        return g;
    endfunction

endpackage

/* src/mqe_in_if.sv */
// Interface: input request channel (movement reports and ticks).
`timescale 1ns / 1ps

interface mqe_in_if;
    logic             valid;
    logic             ready;
    mqe_pkg::t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/mqe_out_if.sv */
// Interface: result request channel (phase pins and button pins).
`timescale 1ns / 1ps

interface mqe_out_if;
    logic              valid;
    logic              ready;
    mqe_pkg::t_out_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/mqe_axis.sv */
// One axis: saturating pending-movement counter and 2-bit quadrature phase.
`timescale 1ns / 1ps

module mqe_axis (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_tick,
    input  logic                                  i_fwd_on_pos,
    input  logic signed [mqe_pkg::DELTA_W-1:0]    i_delta,
    output logic [mqe_pkg::PHASE_W-1:0]           o_phase_next
);

    logic signed [mqe_pkg::PENDING_W-1:0] r_pending;
    logic signed [mqe_pkg::PENDING_W-1:0] n_pending;
    logic [mqe_pkg::PHASE_W-1:0]          r_phase;
    logic [mqe_pkg::PHASE_W-1:0]          n_phase;
    logic signed [mqe_pkg::PENDING_W:0]   sum;
    logic                                 pos;
    logic                                 neg;
    logic                                 fwd;

    assign sum = {r_pending[mqe_pkg::PENDING_W-1], r_pending}
               + {{(mqe_pkg::PENDING_W+1-mqe_pkg::DELTA_W){i_delta[mqe_pkg::DELTA_W-1]}},
                  i_delta};

    assign neg = r_pending[mqe_pkg::PENDING_W-1];
    assign pos = !neg && (r_pending != '0);
    assign fwd = pos ? i_fwd_on_pos : !i_fwd_on_pos;

    always_comb begin
        n_pending = r_pending;
        n_phase   = r_phase;
        if (i_tick) begin
            if (pos || neg) begin
                n_phase   = r_phase + (fwd ? mqe_pkg::PHASE_FWD : mqe_pkg::PHASE_BACK);
                n_pending = pos ? r_pending - 16'sd1 : r_pending + 16'sd1;
            end
        end else begin
            // clamp at the 16-bit limits instead of wrapping
            if (sum[mqe_pkg::PENDING_W] != sum[mqe_pkg::PENDING_W-1]) begin
                n_pending = sum[mqe_pkg::PENDING_W] ? {1'b1, {(mqe_pkg::PENDING_W-1){1'b0}}}
                                                    : {1'b0, {(mqe_pkg::PENDING_W-1){1'b1}}};
            end else begin
                n_pending = sum[mqe_pkg::PENDING_W-1:0];
            end
        end
    end

    assign o_phase_next = i_en ? n_phase : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_phase   <= '0;
        end else if (i_en) begin
            r_pending <= n_pending;
            r_phase   <= n_phase;
        end
    end

endmodule

/* src/mouse_quadrature_emulator.sv */
// Top level: quadrature mouse emulator with request channels and configuration port.
//
//  channel | dir | payload                                         | handshake
//  i_req   | in  | opcode, delta_x, delta_y, button_bits           | valid/ready
//  o_rsp   | out | pin_x1, pin_x2, pin_y1, pin_y2, buttons (low)   | valid/ready
//  i_cfg_* | in  | register index, write data                       | write enable
//
// On each accepted request the axis counters, phases and button levels
// update at the accepting edge and the result lands in the output register
// at the same edge; one request is accepted per cycle while the output is not stalled.
// Reset is synchronous: counters and phases clear, buttons read released,
// both configuration bits clear, and the output register empties.
// A stalled result holds in the output register; a new request is still
// taken in the cycle the held result is taken.
`timescale 1ns / 1ps

module mouse_quadrature_emulator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    mqe_in_if.sink                               i_req,
    mqe_out_if.source                            o_rsp,
    input  logic                                 i_cfg_we,
    input  logic [mqe_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mqe_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    logic                          r_alt_pinout;
    logic                          r_swap_buttons;
    logic [1:0]                    r_buttons;
    logic [1:0]                    n_buttons;
    logic                          r_out_valid;
    mqe_pkg::t_out_req             r_out;
    mqe_pkg::t_out_req             n_out;
    logic                          accept;
    logic                          is_tick;
    logic                          left_raw;
    logic                          right_raw;
    logic [mqe_pkg::PHASE_W-1:0]   phase_x_next;
    logic [mqe_pkg::PHASE_W-1:0]   phase_y_next;
    logic [mqe_pkg::PHASE_W-1:0]   gx;
    logic [mqe_pkg::PHASE_W-1:0]   gy;

    // Take a new request whenever the output register is empty or draining
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_tick     = (i_req.data.opcode == mqe_pkg::OP_TICK);

    // Positive X steps the phase backward, positive Y steps it forward
    mqe_axis u_axis_x (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_tick       (is_tick),
        .i_fwd_on_pos (1'b0),
        .i_delta      (i_req.data.delta_x),
        .o_phase_next (phase_x_next)
    );

    mqe_axis u_axis_y (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_tick       (is_tick),
        .i_fwd_on_pos (1'b1),
        .i_delta      (i_req.data.delta_y),
        .o_phase_next (phase_y_next)
    );

    // Latch buttons on a report: swap if asked, store as active-low levels
    always_comb begin
        left_raw  = r_swap_buttons ? i_req.data.button_bits[1] : i_req.data.button_bits[0];
        right_raw = r_swap_buttons ? i_req.data.button_bits[0] : i_req.data.button_bits[1];
        n_buttons = r_buttons;
        if (!is_tick) begin
            n_buttons = {~right_raw, ~left_raw};
        end
    end

    // Map phases onto the pins for the current connector wiring
    always_comb begin
        gx = mqe_pkg::gray_of(phase_x_next);
        gy = mqe_pkg::gray_of(phase_y_next);
        n_out.pin_x1         = gx[0];
        n_out.pin_y1         = gy[0];
        n_out.pin_x2         = r_alt_pinout ? gy[1] : gx[1];
        n_out.pin_y2         = r_alt_pinout ? gx[1] : gy[1];
        n_out.left_button_n  = n_buttons[0];
        n_out.right_button_n = n_buttons[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_pinout   <= 1'b0;
            r_swap_buttons <= 1'b0;
            r_buttons      <= mqe_pkg::BUTTONS_RELEASED;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mqe_pkg::CFG_ALT_PINOUT:   r_alt_pinout   <= i_cfg_wdata[0];
                    mqe_pkg::CFG_SWAP_BUTTONS: r_swap_buttons <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_buttons   <= n_buttons;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: hold while stalled, load on accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule
